@@ design/hsit_pkg.sv @@
package hsit_pkg;

  localparam int NameBytes = 16;
  localparam int CharBits = 8 * NameBytes;
  localparam logic [6:0] SymbolLimit = 7'd64;

  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_ADDED = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

  typedef enum logic [2:0] {
    HOP_ADD_BYTE,
    HOP_MIX10,
    HOP_MIX6,
    HOP_FIN3,
    HOP_FIN11,
    HOP_FIN15
  } hash_op_t;

  typedef struct packed {
    logic     en;
    logic     clear;
    hash_op_t op;
  } hash_ctl_t;

  typedef struct packed {
    logic                valid;
    logic [4:0]          length;
    logic [CharBits-1:0] chars;
    logic [5:0]          symbol;
  } slot_entry_t;

endpackage

@@ design/hsit_hash_unit.sv @@
module hsit_hash_unit
  import hsit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  hash_ctl_t   ctl,
  input  logic [7:0]  char_in,
  output logic [31:0] hash
);

  logic [31:0] hash_next;

  always_comb begin
    unique case (ctl.op)
      HOP_ADD_BYTE: hash_next = hash + {24'd0, char_in};
      HOP_MIX10:    hash_next = hash + (hash << 10);
      HOP_MIX6:     hash_next = hash ^ (hash >> 6);
      HOP_FIN3:     hash_next = hash + (hash << 3);
      HOP_FIN11:    hash_next = hash ^ (hash >> 11);
      HOP_FIN15:    hash_next = hash + (hash << 15);
      default:      hash_next = hash;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hash <= '0;
    end else if (ctl.en) begin
      hash <= hash_next;
    end
  end

endmodule

@@ design/hsit_slot_store.sv @@
module hsit_slot_store
  import hsit_pkg::*;
#(
  parameter int SLOTS = 64,
  localparam int IdxW = $clog2(SLOTS)
)(
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  slot_entry_t     wr_data,
  input  logic [IdxW-1:0] rd_addr,
  output slot_entry_t     rd_data
);

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/hashed_symbol_interning_table.sv @@
// Non-final byte: accepted in S_IDLE, then busy in S_MIX10 and S_MIX6 (three hash steps).
// Final byte: three hash steps, then, unless the name is over-long, three finishing steps,
// the hash modulo the slot count in S_MOD (S_MOD, S_MUL, S_SUB when TABLE_SLOTS is not a
// power of two), S_READ and S_CHECK per slot probed; S_DONE loads the result register.
// Reset (rst, synchronous): clears the pending name, hash and symbol counter, then
// sweeps every slot of the slot store in S_CLEAR with s_axis_tready low.
module hashed_symbol_interning_table
  import hsit_pkg::*;
#(
  parameter int TABLE_SLOTS = 64,
  parameter int MAX_NAME_CHARS = 16
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] name_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [5:0] symbol_number, [7:6] lookup_status
);

  localparam int IdxW = $clog2(TABLE_SLOTS);
  localparam bit Pow2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam int ModShift = 28 + IdxW;
  localparam logic [29:0] ModRecip =
      30'(((64'd1 << ModShift) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
  localparam logic [11:0] ModFold = 12'((64'd1 << 16) % 64'(TABLE_SLOTS));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIX10, S_MIX6, S_FIN3, S_FIN11, S_FIN15,
    S_MOD, S_MUL, S_SUB, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t              state;
  logic                last_q;
  logic                overlong;
  logic [4:0]          len;
  logic [CharBits-1:0] chars;
  logic [6:0]          sym_count;
  logic [IdxW-1:0]     pos;
  logic [IdxW-1:0]     tries;
  logic [27:0]         mod_x;
  logic [27:0]         mod_q;
  logic [5:0]          res_symbol;
  logic [1:0]          res_status;

  hash_ctl_t   hctl;
  logic [31:0] hash;
  logic        wr_en;
  slot_entry_t wr_data;
  slot_entry_t rd_data;
  logic [57:0]     mod_prod;
  logic [27:0]     mod_rem;
  logic [IdxW-1:0] pos_inc;
  logic            name_match;

  hsit_hash_unit u_hash (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hctl),
    .char_in (s_axis_tdata),
    .hash    (hash)
  );

  hsit_slot_store #(.SLOTS(TABLE_SLOTS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_data),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    hctl.en = 1'b1;
    hctl.clear = 1'b0;
    unique case (state)
      S_IDLE:  begin
        hctl.op = HOP_ADD_BYTE;
        hctl.en = s_axis_tvalid;
      end
      S_MIX10: hctl.op = HOP_MIX10;
      S_MIX6:  hctl.op = HOP_MIX6;
      S_FIN3:  hctl.op = HOP_FIN3;
      S_FIN11: hctl.op = HOP_FIN11;
      S_FIN15: hctl.op = HOP_FIN15;
      S_DONE:  begin
        hctl.op = HOP_ADD_BYTE;
        hctl.en = 1'b0;
        hctl.clear = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        hctl.op = HOP_ADD_BYTE;
        hctl.en = 1'b0;
      end
    endcase
  end

  assign mod_prod = 58'(mod_x) * 58'(ModRecip);
  assign mod_rem = mod_x - mod_q * 28'(TABLE_SLOTS);
  assign pos_inc = (pos == IdxW'(TABLE_SLOTS - 1)) ? '0 : pos + 1'b1;
  assign name_match = (rd_data.length == len) && (rd_data.chars == chars);

  always_comb begin
    wr_en = 1'b0;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == S_CHECK && !rd_data.valid && !sym_count[6]) begin
      wr_en = 1'b1;
      wr_data.valid = 1'b1;
      wr_data.length = len;
      wr_data.chars = chars;
      wr_data.symbol = sym_count[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pos <= '0;
      overlong <= 1'b0;
      len <= '0;
      chars <= '0;
      sym_count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (pos == IdxW'(TABLE_SLOTS - 1)) begin
            pos <= '0;
            state <= S_IDLE;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            last_q <= s_axis_tlast;
            if (overlong || len >= 5'(MAX_NAME_CHARS)) begin
              overlong <= 1'b1;
            end else begin
              chars[{len[3:0], 3'b000} +: 8] <= s_axis_tdata;
              len <= len + 1'b1;
            end
            state <= S_MIX10;
          end
        end
        S_MIX10: state <= S_MIX6;
        S_MIX6: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (overlong) begin
            res_symbol <= '0;
            res_status <= STATUS_TOO_LONG;
            state <= S_DONE;
          end else begin
            state <= S_FIN3;
          end
        end
        S_FIN3:  state <= S_FIN11;
        S_FIN11: state <= S_FIN15;
        S_FIN15: state <= S_MOD;
        S_MOD: begin
          tries <= '0;
          if (Pow2) begin
            pos <= hash[IdxW-1:0];
            state <= S_READ;
          end else begin
            mod_x <= {12'd0, hash[31:16]} * {16'd0, ModFold} + {12'd0, hash[15:0]};
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mod_q <= 28'(mod_prod >> ModShift);
          state <= S_SUB;
        end
        S_SUB: begin
          pos <= mod_rem[IdxW-1:0];
          state <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (!rd_data.valid) begin
            if (sym_count[6]) begin
              res_symbol <= '0;
              res_status <= STATUS_FULL;
            end else begin
              res_symbol <= sym_count[5:0];
              res_status <= STATUS_ADDED;
              sym_count <= sym_count + 1'b1;
            end
            state <= S_DONE;
          end else if (name_match) begin
            res_symbol <= rd_data.symbol;
            res_status <= STATUS_FOUND;
            state <= S_DONE;
          end else if (tries == IdxW'(TABLE_SLOTS - 1)) begin
            res_symbol <= '0;
            res_status <= STATUS_FULL;
            state <= S_DONE;
          end else begin
            tries <= tries + 1'b1;
            pos <= pos_inc;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {res_status, res_symbol};
            m_axis_tvalid <= 1'b1;
            overlong <= 1'b0;
            len <= '0;
            chars <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    sym_count <= SymbolLimit)
    else $error("symbol counter past limit");

  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    len <= 5'(MAX_NAME_CHARS))
    else $error("pending length past limit");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[7:6] == STATUS_FULL ||
                      m_axis_tdata[7:6] == STATUS_TOO_LONG)
    |-> m_axis_tdata[5:0] == 6'd0)
    else $error("failed lookup carries a symbol");

  a_write_guard: assert property (@(posedge clk) disable iff (rst)
    wr_en && state != S_CLEAR |-> !sym_count[6] && !rd_data.valid)
    else $error("slot write past limit or over valid slot");

  a_added_count: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && wr_en |=> sym_count == $past(sym_count) + 7'd1)
    else $error("symbol counter did not advance on insert");
`endif

endmodule

@@ verif/hashed_symbol_interning_table_tb.sv @@
`timescale 1ns / 100ps

module hashed_symbol_interning_table_tb;
  import hsit_pkg::*;

  localparam int TableSlots = 64;
  localparam int MaxNameChars = NameBytes;
  localparam int NameBufBits = 8 * (MaxNameChars + 4);
  localparam int StallLimit = 3000;
  localparam int DrainCycles = 200;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] symbol;
  } lookup_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int stall_cycles = 0;

  bit                slot_used [TableSlots];
  bit [4:0]          slot_len [TableSlots];
  bit [CharBits-1:0] slot_text [TableSlots];
  bit [5:0]          slot_sym [TableSlots];
  bit [6:0]          symbols_issued;

  bit [CharBits-1:0] name_text;
  bit [4:0]          name_len;
  bit [31:0]         name_hash;
  bit                name_over;

  lookup_t expected_lookups[$];
  lookup_t want_lookup;

  logic [NameBufBits-1:0] pool_text[$];
  int                     pool_len[$];

  hashed_symbol_interning_table u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic lookup_t probe_table();
    bit [31:0] h;
    int pos;
    lookup_t res;
    h = name_hash;
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    pos = int'(h % TableSlots);
    res.status = STATUS_FULL;
    res.symbol = 6'd0;
    for (int tries = 0; tries < TableSlots; tries++) begin
      if (!slot_used[pos]) begin
        if (symbols_issued >= SymbolLimit) break;
        slot_used[pos] = 1'b1;
        slot_len[pos] = name_len;
        slot_text[pos] = name_text;
        slot_sym[pos] = symbols_issued[5:0];
        symbols_issued = symbols_issued + 7'd1;
        res.status = STATUS_ADDED;
        res.symbol = slot_sym[pos];
        return res;
      end
      if (slot_len[pos] == name_len && slot_text[pos] == name_text) begin
        res.status = STATUS_FOUND;
        res.symbol = slot_sym[pos];
        return res;
      end
      pos = (pos + 1) % TableSlots;
    end
    return res;
  endfunction

  function automatic void intern_byte(input bit [7:0] c, input bit last);
    lookup_t res;
    name_hash = name_hash + {24'd0, c};
    name_hash = name_hash + (name_hash << 10);
    name_hash = name_hash ^ (name_hash >> 6);
    if (name_over || name_len >= MaxNameChars) begin
      name_over = 1'b1;
    end else begin
      name_text[8*name_len +: 8] = c;
      name_len = name_len + 5'd1;
    end
    if (!last) return;
    if (name_over) begin
      res.status = STATUS_TOO_LONG;
      res.symbol = 6'd0;
    end else begin
      res = probe_table();
    end
    expected_lookups.push_back(res);
    name_text = '0;
    name_len = '0;
    name_hash = '0;
    name_over = 1'b0;
  endfunction

  function automatic void remember_name(input logic [NameBufBits-1:0] text, input int len);
    pool_text.push_back(text);
    pool_len.push_back(len);
  endfunction

  function automatic logic [NameBufBits-1:0] random_text(input int len);
    logic [NameBufBits-1:0] text;
    text = '0;
    for (int i = 0; i < len; i++) text[8*i +: 8] = 8'($urandom_range(255));
    return text;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    intern_byte(c, last);
  endtask

  task automatic send_name(input logic [NameBufBits-1:0] text, input int len);
    for (int i = 0; i < len; i++) send_byte(text[8*i +: 8], i == len - 1);
  endtask

  task automatic test_basic_names();
    send_name('0, 1);
    send_name({{(NameBufBits-8){1'b0}}, 8'hFF}, 1);
    send_name('0, 2);
    send_name('0, 1);
  endtask

  task automatic test_length_limit();
    logic [NameBufBits-1:0] text;
    text = random_text(MaxNameChars + 1);
    send_name(text, MaxNameChars);
    remember_name(text & ~({NameBufBits{1'b1}} << (8 * MaxNameChars)), MaxNameChars);
    send_name(text, MaxNameChars + 1);
  endtask

  task automatic test_random_names(input int byte_budget);
    logic [NameBufBits-1:0] text;
    int sent;
    int pick;
    int len;
    int r;
    sent = 0;
    while (sent < byte_budget) begin
      r = $urandom_range(99);
      if (r < 45 && pool_len.size() > 0) begin
        pick = $urandom_range(pool_len.size() - 1);
        text = pool_text[pick];
        len = pool_len[pick];
      end else if (r < 60 && pool_len.size() > 0) begin
        pick = $urandom_range(pool_len.size() - 1);
        text = pool_text[pick];
        len = pool_len[pick];
        if (len > 1 && $urandom_range(1) == 1) begin
          len--;
          text[8*len +: 8] = 8'h00;
        end else if (len < MaxNameChars) begin
          text[8*len +: 8] = ($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(255));
          len++;
        end
        remember_name(text, len);
      end else if (r < 92) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(MaxNameChars, 1) : $urandom_range(4, 1);
        text = random_text(len);
        remember_name(text, len);
      end else begin
        len = $urandom_range(MaxNameChars + 4, MaxNameChars + 1);
        text = random_text(len);
      end
      send_name(text, len);
      sent += len;
    end
  endtask

  task automatic test_table_full();
    logic [NameBufBits-1:0] text;
    int pick;
    while (symbols_issued < SymbolLimit) begin
      text = random_text(2);
      send_name(text, 2);
      remember_name(text, 2);
    end
    repeat (6) send_name(random_text(3), 3);
    repeat (4) begin
      pick = $urandom_range(pool_len.size() - 1);
      send_name(pool_text[pick], pool_len[pick]);
    end
    send_name(random_text(MaxNameChars + 1), MaxNameChars + 1);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want_lookup = expected_lookups.pop_front();
        if (m_axis_tdata[5:0] !== want_lookup.symbol) begin
          $display("%0t: symbol_number expected %0d actual %0d",
                   $time, want_lookup.symbol, m_axis_tdata[5:0]);
          error_count++;
        end
        if (m_axis_tdata[7:6] !== want_lookup.status) begin
          $display("%0t: lookup_status expected %0d actual %0d",
                   $time, want_lookup.status, m_axis_tdata[7:6]);
          error_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("hashed_symbol_interning_table_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 85;
    test_basic_names();
    test_length_limit();
    test_random_names(140);
    send_idle_pct = 85;
    recv_idle_pct = 25;
    test_random_names(140);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_names(140);
    test_table_full();
    s_axis_tvalid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("hashed_symbol_interning_table_tb: PASS");
    end else begin
      $display("hashed_symbol_interning_table_tb: FAIL");
    end
    $finish;
  end

endmodule
